// File: src/fk_pkg.sv
`timescale 1ns / 1ps
package fk_pkg;

   localparam int CORDIC_STAGES = 20;
   localparam int NUM_LANES = 6;
   localparam int NUM_TRIG = 12;
   localparam int NUM_TERMS = 34;
   localparam int TERM_FACTORS = 5;
   localparam int NUM_ROT = 9;

   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [33:0] CORDIC_ATAN [CORDIC_STAGES] = '{
      34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756, 34'sd42667331,
      34'sd21354465, 34'sd10679838, 34'sd5340245, 34'sd2670163, 34'sd1335087,
      34'sd667544, 34'sd333772, 34'sd166886, 34'sd83443, 34'sd41722,
      34'sd20861, 34'sd10430, 34'sd5215, 34'sd2608, 34'sd1304
   };

   localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

   // trig value codes: sine at 2*lane, cosine at 2*lane+1, unity last
   typedef logic [3:0] trig_sel_type;
   localparam trig_sel_type S1 = 4'd0;
   localparam trig_sel_type C1 = 4'd1;
   localparam trig_sel_type S2 = 4'd2;
   localparam trig_sel_type C2 = 4'd3;
   localparam trig_sel_type S23 = 4'd4;
   localparam trig_sel_type C23 = 4'd5;
   localparam trig_sel_type S4 = 4'd6;
   localparam trig_sel_type C4 = 4'd7;
   localparam trig_sel_type S5 = 4'd8;
   localparam trig_sel_type C5 = 4'd9;
   localparam trig_sel_type S6 = 4'd10;
   localparam trig_sel_type C6 = 4'd11;
   localparam trig_sel_type ONE = 4'd12;

   typedef logic [3:0] rot_sel_type;
   localparam rot_sel_type R_NX = 4'd0;
   localparam rot_sel_type R_OX = 4'd1;
   localparam rot_sel_type R_AX = 4'd2;
   localparam rot_sel_type R_NY = 4'd3;
   localparam rot_sel_type R_OY = 4'd4;
   localparam rot_sel_type R_AY = 4'd5;
   localparam rot_sel_type R_NZ = 4'd6;
   localparam rot_sel_type R_OZ = 4'd7;
   localparam rot_sel_type R_AZ = 4'd8;

   // factors of each product term, multiplied left to right
   localparam trig_sel_type TERM_FAC [NUM_TERMS][TERM_FACTORS] = '{
      '{C4, C5, S1, C23, ONE}, '{C1, C5, S4, ONE, ONE}, '{S1, S23, S5, ONE, ONE},
      '{C4, S5, S6, S1, C23}, '{C1, S5, S4, S6, ONE}, '{C5, S6, S1, S23, ONE},
      '{S4, C6, S1, C23, ONE}, '{C1, C4, C6, ONE, ONE},
      '{C4, S5, C6, S1, C23}, '{C1, S5, S4, C6, ONE}, '{C5, C6, S1, S23, ONE},
      '{S6, S4, S1, C23, ONE}, '{C1, C4, S6, ONE, ONE},
      '{C1, C4, C5, C23, ONE}, '{C1, S23, S5, ONE, ONE}, '{C5, S4, S1, ONE, ONE},
      '{C1, C4, S5, S6, C23}, '{C1, C5, S6, S23, ONE}, '{C1, S4, C6, C23, ONE},
      '{S5, S4, S6, S1, ONE}, '{C4, C6, S1, ONE, ONE},
      '{C1, C4, S5, C6, C23}, '{C1, C5, C6, S23, ONE}, '{C1, S6, S4, C23, ONE},
      '{S5, S4, C6, S1, ONE}, '{C4, S6, S1, ONE, ONE},
      '{S23, C4, C5, ONE, ONE}, '{C23, S5, ONE, ONE, ONE},
      '{C4, S5, S6, S23, ONE}, '{C5, S6, C23, ONE, ONE}, '{S23, S4, C6, ONE, ONE},
      '{C4, S5, C6, S23, ONE}, '{C5, C6, C23, ONE, ONE}, '{S23, S4, S6, ONE, ONE}
   };

   localparam logic TERM_NEG [NUM_TERMS] = '{
      1'b0, 1'b0, 1'b1,
      1'b0, 1'b0, 1'b0, 1'b1, 1'b0,
      1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
      1'b1, 1'b0, 1'b0,
      1'b1, 1'b1, 1'b0, 1'b0, 1'b0,
      1'b1, 1'b1, 1'b1, 1'b0, 1'b1,
      1'b1, 1'b1,
      1'b1, 1'b0, 1'b0,
      1'b1, 1'b0, 1'b1
   };

   localparam rot_sel_type TERM_OUT [NUM_TERMS] = '{
      R_NX, R_NX, R_NX,
      R_OX, R_OX, R_OX, R_OX, R_OX,
      R_AX, R_AX, R_AX, R_AX, R_AX,
      R_NY, R_NY, R_NY,
      R_OY, R_OY, R_OY, R_OY, R_OY,
      R_AY, R_AY, R_AY, R_AY, R_AY,
      R_NZ, R_NZ,
      R_OZ, R_OZ, R_OZ,
      R_AZ, R_AZ, R_AZ
   };

   // one q1.14 product step, rounded half up
   function automatic logic signed [15:0] mul_q14(input logic signed [15:0] a,
                                                  input logic signed [15:0] b);
      logic signed [31:0] pr;
      logic signed [31:0] rs;
      pr = a * b;
      rs = (pr + 32'sd8192) >>> 14;
      return rs[15:0];
   endfunction

   // q3.30 cordic result to q1.14, clamped, turned back by a half circle if flipped
   function automatic logic signed [15:0] round_q14(input logic signed [33:0] v,
                                                    input logic flip);
      logic signed [33:0] rs;
      logic signed [17:0] r;
      rs = (v + 34'sd32768) >>> 16;
      r = rs[17:0];
      if (r > 18'sd16384) r = 18'sd16384;
      if (r < -18'sd16384) r = -18'sd16384;
      if (flip) r = -r;
      return r[15:0];
   endfunction

endpackage

// File: src/fk_cordic_cell.sv
`timescale 1ns / 1ps
module fk_cordic_cell #(
   parameter int STAGE = 0
) (
   input  logic               clock,
   input  logic               en,
   input  logic signed [33:0] x_in,
   input  logic signed [33:0] y_in,
   input  logic signed [33:0] z_in,
   input  logic               flip_in,
   output logic signed [33:0] x_out,
   output logic signed [33:0] y_out,
   output logic signed [33:0] z_out,
   output logic               flip_out
);

   logic signed [33:0] x_ff, y_ff, z_ff;
   logic               flip_ff;
   logic signed [33:0] xs, ys;

   assign xs = x_in >>> STAGE;
   assign ys = y_in >>> STAGE;

   always_ff @(posedge clock) begin
      if (en) begin
         if (!z_in[33]) begin
            x_ff <= x_in - ys;
            y_ff <= y_in + xs;
            z_ff <= z_in - fk_pkg::CORDIC_ATAN[STAGE];
         end else begin
            x_ff <= x_in + ys;
            y_ff <= y_in - xs;
            z_ff <= z_in + fk_pkg::CORDIC_ATAN[STAGE];
         end
         flip_ff <= flip_in;
      end
   end

   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;
   assign flip_out = flip_ff;

endmodule

// File: src/fk_term.sv
`timescale 1ns / 1ps
module fk_term (
   input  logic               clock,
   input  logic               en,
   input  logic signed [15:0] fac_in [fk_pkg::TERM_FACTORS],
   output logic signed [15:0] prod_out
);

   localparam int STEPS = fk_pkg::TERM_FACTORS - 1;

   logic signed [15:0] p_ff [STEPS];
   logic signed [15:0] fac_ff [STEPS-1][fk_pkg::TERM_FACTORS];

   // one pairwise product per cell, remaining factors ride along
   always_ff @(posedge clock) begin
      if (en) begin
         p_ff[0] <= fk_pkg::mul_q14(fac_in[0], fac_in[1]);
         fac_ff[0] <= fac_in;
         for (int s = 1; s < STEPS; s++) begin
            p_ff[s] <= fk_pkg::mul_q14(p_ff[s-1], fac_ff[s-1][s+1]);
         end
         for (int s = 1; s < STEPS-1; s++) begin
            fac_ff[s] <= fac_ff[s-1];
         end
      end
   end

   assign prod_out = p_ff[STEPS-1];

endmodule

// File: src/fk_pose.sv
`timescale 1ns / 1ps
module fk_pose (
   input  logic               clock,
   input  logic               en,
   input  logic signed [15:0] trig_in [fk_pkg::NUM_TRIG],
   input  logic [13:0]        base_height,
   input  logic [13:0]        upper_arm_length,
   input  logic [13:0]        forearm_length,
   output logic signed [15:0] rot_out [fk_pkg::NUM_ROT],
   output logic signed [16:0] pos_out [3]
);

   logic signed [15:0] trig_ext [fk_pkg::NUM_TRIG+1];
   logic signed [15:0] term_p [fk_pkg::NUM_TERMS];

   always_comb begin
      for (int i = 0; i < fk_pkg::NUM_TRIG; i++) trig_ext[i] = trig_in[i];
      trig_ext[fk_pkg::NUM_TRIG] = fk_pkg::ONE_Q14;
   end

   for (genvar t = 0; t < fk_pkg::NUM_TERMS; t++) begin : g_term
      logic signed [15:0] fac [fk_pkg::TERM_FACTORS];
      for (genvar k = 0; k < fk_pkg::TERM_FACTORS; k++) begin : g_fac
         assign fac[k] = trig_ext[fk_pkg::TERM_FAC[t][k]];
      end
      fk_term u_term (
         .clock   (clock),
         .en      (en),
         .fac_in  (fac),
         .prod_out(term_p[t])
      );
   end

   // position path, four stages to line up with the product cells
   logic signed [29:0] ps23_ff, ps2_ff, pc23_ff, pc2_ff;
   logic signed [15:0] s1a_ff, c1a_ff, s1b_ff, c1b_ff;
   logic signed [30:0] reach_ff, zsum_ff, zsumc_ff;
   logic signed [46:0] mx_ff, my_ff;
   logic signed [19:0] px_ff, py_ff, pz_ff;
   logic signed [46:0] rx, ry;
   logic signed [30:0] rz;

   assign rx = (mx_ff + 47'sd134217728) >>> 28;
   assign ry = (my_ff + 47'sd134217728) >>> 28;
   assign rz = (zsumc_ff + 31'sd8192) >>> 14;

   always_ff @(posedge clock) begin
      if (en) begin
         ps23_ff <= 30'(trig_in[fk_pkg::S23] * $signed({1'b0, forearm_length}));
         ps2_ff  <= 30'(trig_in[fk_pkg::S2] * $signed({1'b0, upper_arm_length}));
         pc23_ff <= 30'(trig_in[fk_pkg::C23] * $signed({1'b0, forearm_length}));
         pc2_ff  <= 30'(trig_in[fk_pkg::C2] * $signed({1'b0, upper_arm_length}));
         s1a_ff  <= trig_in[fk_pkg::S1];
         c1a_ff  <= trig_in[fk_pkg::C1];
         reach_ff <= 31'(ps23_ff) + 31'(ps2_ff);
         zsum_ff  <= 31'(pc23_ff) + 31'(pc2_ff);
         s1b_ff  <= s1a_ff;
         c1b_ff  <= c1a_ff;
         mx_ff   <= 47'(s1b_ff * reach_ff);
         my_ff   <= 47'(c1b_ff * reach_ff);
         zsumc_ff <= zsum_ff;
         px_ff   <= rx[19:0];
         py_ff   <= -ry[19:0];
         pz_ff   <= 20'(rz) + 20'($signed({1'b0, base_height}));
      end
   end

   logic signed [19:0] rsum [fk_pkg::NUM_ROT];
   logic signed [19:0] tv;

   always_comb begin
      for (int r = 0; r < fk_pkg::NUM_ROT; r++) rsum[r] = '0;
      for (int t = 0; t < fk_pkg::NUM_TERMS; t++) begin
         tv = 20'(term_p[t]);
         if (fk_pkg::TERM_NEG[t]) tv = -tv;
         rsum[fk_pkg::TERM_OUT[t]] = rsum[fk_pkg::TERM_OUT[t]] + tv;
      end
   end

   logic signed [15:0] rot_ff [fk_pkg::NUM_ROT];
   logic signed [16:0] pos_ff [3];
   logic signed [19:0] pv [3];

   assign pv[0] = px_ff;
   assign pv[1] = py_ff;
   assign pv[2] = pz_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < fk_pkg::NUM_ROT; r++) begin
            if (rsum[r] > 20'sd16384) rot_ff[r] <= 16'sd16384;
            else if (rsum[r] < -20'sd16384) rot_ff[r] <= -16'sd16384;
            else rot_ff[r] <= rsum[r][15:0];
         end
         for (int a = 0; a < 3; a++) begin
            if (pv[a] > 20'sd65535) pos_ff[a] <= 17'sd65535;
            else if (pv[a] < -20'sd65536) pos_ff[a] <= -17'sd65536;
            else pos_ff[a] <= pv[a][16:0];
         end
      end
   end

   assign rot_out = rot_ff;
   assign pos_out = pos_ff;

endmodule

// File: src/six_axis_forward_kinematics_top.sv
`timescale 1ns / 1ps
// six-axis arm forward kinematics: one joint vector in, one 3x4 tool pose out.
// the block is a fixed pipeline of 27 register stages and takes one transfer per
// cycle unless held; the whole pipeline advances together and only holds while a
// finished result waits on rsp_tready, so the rate is set by the output side alone.
// six lanes of 20 cordic cells form sine and cosine of joints one, two, four, five
// and six (and of joints two plus three), then 34 product chains of four q1.14
// multiply cells and a sum stage build the rotation, beside a four-stage position
// path using the three link length registers. the user must write link lengths
// through the csr port only while the block is idle; the block does not enforce it.
module six_axis_forward_kinematics_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // joint1..joint6 angles, 16 bits each, joint1 lowest
   input  logic [95:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // normal_x orient_x approach_x pos_x(17) normal_y orient_y approach_y pos_y(17)
   // normal_z orient_z approach_z pos_z(17), 5 zero pad bits on top
   output logic [199:0] rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [13:0]  csr_data
);

   localparam int LATENCY = fk_pkg::CORDIC_STAGES + 7;
   localparam logic [1:0] REG_BASE = 2'd0;
   localparam logic [1:0] REG_UPPER = 2'd1;
   localparam logic [1:0] REG_FORE = 2'd2;

   logic en;
   logic [LATENCY-1:0] vld_ff;

   // pipeline moves unless a result is stuck at the output
   assign en = !rsp_tvalid || rsp_tready;
   // no transfers are taken while in reset
   assign req_tready = en && !reset;
   assign rsp_tvalid = vld_ff[LATENCY-1];
   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LATENCY-2:0], req_tvalid};
      end
   end

   // link length registers
   logic [13:0] base_ff, upper_ff, fore_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= 14'd3600;
         upper_ff <= 14'd6736;
         fore_ff  <= 14'd6080;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_BASE:  base_ff  <= csr_data;
            REG_UPPER: upper_ff <= csr_data;
            REG_FORE:  fore_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // lane angles: joint1, joint2, joint2+joint3, joint4, joint5, joint6
   logic [15:0] ang [fk_pkg::NUM_LANES];
   assign ang[0] = req_tdata[15:0];
   assign ang[1] = req_tdata[31:16];
   assign ang[2] = req_tdata[31:16] + req_tdata[47:32];
   assign ang[3] = req_tdata[63:48];
   assign ang[4] = req_tdata[79:64];
   assign ang[5] = req_tdata[95:80];

   logic signed [15:0] trig_ff [fk_pkg::NUM_TRIG];

   for (genvar l = 0; l < fk_pkg::NUM_LANES; l++) begin : g_lane
      logic signed [33:0] cx [fk_pkg::CORDIC_STAGES+1];
      logic signed [33:0] cy [fk_pkg::CORDIC_STAGES+1];
      logic signed [33:0] cz [fk_pkg::CORDIC_STAGES+1];
      logic               cf [fk_pkg::CORDIC_STAGES+1];
      logic               flip;
      logic [15:0]        u;
      logic signed [33:0] x0_ff, y0_ff, z0_ff;
      logic               f0_ff;

      // second and third quadrants are turned by a half circle
      assign flip = ang[l][15] ^ ang[l][14];
      assign u = flip ? (ang[l] ^ 16'h8000) : ang[l];

      always_ff @(posedge clock) begin
         if (en) begin
            x0_ff <= fk_pkg::CORDIC_GAIN;
            y0_ff <= '0;
            z0_ff <= $signed({{2{u[15]}}, u, 16'h0000});
            f0_ff <= flip;
         end
      end

      assign cx[0] = x0_ff;
      assign cy[0] = y0_ff;
      assign cz[0] = z0_ff;
      assign cf[0] = f0_ff;

      for (genvar s = 0; s < fk_pkg::CORDIC_STAGES; s++) begin : g_cell
         fk_cordic_cell #(.STAGE(s)) u_cell (
            .clock   (clock),
            .en      (en),
            .x_in    (cx[s]),
            .y_in    (cy[s]),
            .z_in    (cz[s]),
            .flip_in (cf[s]),
            .x_out   (cx[s+1]),
            .y_out   (cy[s+1]),
            .z_out   (cz[s+1]),
            .flip_out(cf[s+1])
         );
      end

      always_ff @(posedge clock) begin
         if (en) begin
            trig_ff[2*l] <= fk_pkg::round_q14(cy[fk_pkg::CORDIC_STAGES],
                                              cf[fk_pkg::CORDIC_STAGES]);
            trig_ff[2*l+1] <= fk_pkg::round_q14(cx[fk_pkg::CORDIC_STAGES],
                                                cf[fk_pkg::CORDIC_STAGES]);
         end
      end
   end

   logic signed [15:0] rot [fk_pkg::NUM_ROT];
   logic signed [16:0] pos [3];

   fk_pose u_pose (
      .clock           (clock),
      .en              (en),
      .trig_in         (trig_ff),
      .base_height     (base_ff),
      .upper_arm_length(upper_ff),
      .forearm_length  (fore_ff),
      .rot_out         (rot),
      .pos_out         (pos)
   );

   assign rsp_tdata = {5'b00000,
      pos[2], rot[fk_pkg::R_AZ], rot[fk_pkg::R_OZ], rot[fk_pkg::R_NZ],
      pos[1], rot[fk_pkg::R_AY], rot[fk_pkg::R_OY], rot[fk_pkg::R_NY],
      pos[0], rot[fk_pkg::R_AX], rot[fk_pkg::R_OX], rot[fk_pkg::R_NX]};

endmodule
